/* design/tmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker mode controller package
// Shared types, mode codes, register indexes and constants.
// ----------------------------------------------------------------------------
package tmc_pkg;

  localparam logic [7:0]  UNPAIRED_ID = 8'hFF;

  // Mode codes.
  localparam logic [2:0] MODE_INIT    = 3'd0;
  localparam logic [2:0] MODE_PAIRING = 3'd1;
  localparam logic [2:0] MODE_SYNCING = 3'd2;
  localparam logic [2:0] MODE_RUNNING = 3'd3;
  localparam logic [2:0] MODE_SLEEP   = 3'd4;
  localparam logic [2:0] MODE_ERROR   = 3'd5;

  // Link sync report codes.
  localparam logic [1:0] SYNC_NONE   = 2'd0;
  localparam logic [1:0] SYNC_LOST   = 2'd1;
  localparam logic [1:0] SYNC_GAINED = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_START_ID       = 3'd0;
  localparam logic [2:0] CFG_START_FAULT    = 3'd1;
  localparam logic [2:0] CFG_PAIRING_TMO    = 3'd2;
  localparam logic [2:0] CFG_SYNC_TMO       = 3'd3;
  localparam logic [2:0] CFG_SLEEP_TMO      = 3'd4;
  localparam logic [2:0] CFG_PAIR_RETRY     = 3'd5;
  localparam logic [2:0] CFG_PAIRING_PRESS  = 3'd6;
  localparam logic [2:0] CFG_SLEEP_PRESS    = 3'd7;

  // Register reset values.
  localparam logic [7:0]  RST_START_ID      = 8'd255;
  localparam logic        RST_START_FAULT   = 1'b0;
  localparam logic [15:0] RST_PAIRING_TMO   = 16'd30000;
  localparam logic [15:0] RST_SYNC_TMO      = 16'd5000;
  localparam logic [15:0] RST_SLEEP_TMO     = 16'd60000;
  localparam logic [15:0] RST_PAIR_RETRY    = 16'd100;
  localparam logic [15:0] RST_PAIRING_PRESS = 16'd5000;
  localparam logic [15:0] RST_SLEEP_PRESS   = 16'd1000;

  // LED blink periods.
  localparam logic [31:0] BLINK_INIT_MS    = 32'd100;
  localparam logic [31:0] BLINK_PAIRING_MS = 32'd500;

  // floor(x / 100) for any 32-bit x is (x * DIV100_MAGIC) >> DIV100_SHIFT.
  localparam logic [31:0] DIV100_MAGIC = 32'h51EB_851F;
  localparam int          DIV100_SHIFT = 37;

  typedef struct packed {
    logic [7:0]  start_id;
    logic        start_fault;
    logic [15:0] pairing_timeout;
    logic [15:0] sync_timeout;
    logic [15:0] sleep_timeout;
    logic [15:0] pair_retry_interval;
    logic [15:0] pairing_press;
    logic [15:0] sleep_press;
  } tmc_cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_down;
    logic [7:0]  link_id;
    logic [1:0]  sync_report;
    logic        link_ack;
    logic [25:0] hundreds;    // floor(now_ms / 100)
  } tmc_item_t;

  typedef struct packed {
    logic sync_lit;     // syncing pattern has the LED on in this slot
    logic err_toggle;   // error pattern toggles the LED in this slot
  } tmc_phase_t;

  typedef struct packed {
    logic       led_on;
    logic [2:0] mode;
    logic       pair_request;
    logic       save_pairing;
    logic       resync_request;
    logic       sleep_request;
    logic       fuse_enable;
    logic       send_enable;
    logic [7:0] paired_id;
  } tmc_result_t;

endpackage

/* design/tmc_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker mode controller input stage
// Input register for one pass; also latches the time in units of 100 ms.
// ----------------------------------------------------------------------------
module tmc_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [31:0]       now_ms_i,
  input  logic              button_down_i,
  input  logic [7:0]        link_id_i,
  input  logic [1:0]        sync_report_i,
  input  logic              link_ack_i,
  input  logic              take_i,
  output logic              vld_o,
  output tmc_pkg::tmc_item_t item_o
);
  import tmc_pkg::*;

  logic      vld_q;
  tmc_item_t item_q;
  logic [63:0] prod;
  logic        load;

  assign in_ready_o = !vld_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  // Reciprocal multiply; the quotient is registered with the beat.
  assign prod = 64'(now_ms_i) * 64'(DIV100_MAGIC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (take_i) begin
      vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.now_ms      <= now_ms_i;
      item_q.button_down <= button_down_i;
      item_q.link_id     <= link_id_i;
      item_q.sync_report <= sync_report_i;
      item_q.link_ack    <= link_ack_i;
      item_q.hundreds    <= prod[DIV100_SHIFT+25:DIV100_SHIFT];
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

/* design/tmc_phase.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker mode controller blink phase
// Slot of the syncing pattern (1 s in 100 ms slots) and the error pattern
// (1.2 s in 200 ms slots) from the time in units of 100 ms.
// ----------------------------------------------------------------------------
module tmc_phase (
  input  logic [25:0]         hundreds_i,
  output tmc_pkg::tmc_phase_t phase_o
);
  import tmc_pkg::*;

  // Residue mod 15: since 16 is 1 mod 15, the nibble sum keeps the residue.
  function automatic logic [3:0] mod15(input logic [27:0] x);
    logic [6:0] s;
    logic [4:0] t;
    s = 7'd0;
    for (int i = 0; i < 7; i++) begin
      s = s + 7'(x[4*i +: 4]);
    end
    t = 5'(s[6:4]) + 5'(s[3:0]);
    if (t >= 5'd15) begin
      t = t - 5'd15;
    end
    return t[3:0];
  endfunction

  logic [24:0] twohundreds;
  logic [3:0]  r_s, r_e;
  logic [3:0]  r5;
  logic [3:0]  r3;

  assign twohundreds = hundreds_i[25:1];

  always_comb begin
    r_s = mod15({2'b00, hundreds_i});
    r_e = mod15({3'b000, twohundreds});
    if (r_s >= 4'd10) begin
      r5 = r_s - 4'd10;
    end else if (r_s >= 4'd5) begin
      r5 = r_s - 4'd5;
    end else begin
      r5 = r_s;
    end
    if (r_e >= 4'd12) begin
      r3 = r_e - 4'd12;
    end else if (r_e >= 4'd9) begin
      r3 = r_e - 4'd9;
    end else if (r_e >= 4'd6) begin
      r3 = r_e - 4'd6;
    end else if (r_e >= 4'd3) begin
      r3 = r_e - 4'd3;
    end else begin
      r3 = r_e;
    end
    // Slot 0 or 2 of ten: even, and 0 or 2 mod 5.
    phase_o.sync_lit = !hundreds_i[0] && (r5 == 4'd0 || r5 == 4'd2);
    // Slots 0..2 of six, by parity and residue mod 3.
    phase_o.err_toggle = (!twohundreds[0] && r3 == 4'd0) ||
                         ( twohundreds[0] && r3 == 4'd1) ||
                         (!twohundreds[0] && r3 == 4'd2);
  end

endmodule

/* design/tmc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker mode controller core
// Mode machine state and the complete update for one main-loop pass.
// ----------------------------------------------------------------------------
module tmc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  tmc_pkg::tmc_item_t   item_i,
  input  tmc_pkg::tmc_phase_t  phase_i,
  input  tmc_pkg::tmc_cfg_t    cfg_i,
  output tmc_pkg::tmc_result_t res_o
);
  import tmc_pkg::*;

  logic        started_q, started_d;
  logic [2:0]  mode_q, mode_d;
  logic [31:0] entry_q, entry_d;
  logic [31:0] last_sync_q, last_sync_d;
  logic [31:0] last_act_q, last_act_d;
  logic [31:0] last_blink_q, last_blink_d;
  logic [31:0] last_strobe_q, last_strobe_d;
  logic [31:0] press_start_q, press_start_d;
  logic        held_q, held_d;
  logic        lamp_q, lamp_d;
  logic        synced_q, synced_d;
  logic [7:0]  own_q, own_d;

  logic [31:0] now;
  logic [31:0] dur;
  logic        pair_req, save, resync, sleep_req;

  assign now = item_i.now_ms;

  always_comb begin
    started_d     = started_q;
    mode_d        = mode_q;
    entry_d       = entry_q;
    last_sync_d   = last_sync_q;
    last_act_d    = last_act_q;
    last_blink_d  = last_blink_q;
    last_strobe_d = last_strobe_q;
    press_start_d = press_start_q;
    held_d        = held_q;
    lamp_d        = lamp_q;
    synced_d      = synced_q;
    own_d         = own_q;
    pair_req      = 1'b0;
    save          = 1'b0;
    resync        = 1'b0;
    sleep_req     = 1'b0;
    dur           = now - press_start_q;

    // First pass after reset picks the starting mode.
    if (!started_q) begin
      started_d   = 1'b1;
      own_d       = cfg_i.start_id;
      if (cfg_i.start_id == UNPAIRED_ID) begin
        mode_d = MODE_PAIRING;
      end else if (cfg_i.start_fault) begin
        mode_d = MODE_ERROR;
      end else begin
        mode_d = MODE_SYNCING;
      end
      entry_d     = now;
      last_sync_d = now;
      last_act_d  = now;
    end

    // Button: a release after a long press changes mode.
    if (item_i.button_down && !held_q) begin
      held_d        = 1'b1;
      press_start_d = now;
    end else if (!item_i.button_down && held_q) begin
      held_d = 1'b0;
      if (dur > 32'(cfg_i.pairing_press)) begin
        mode_d  = MODE_PAIRING;
        entry_d = now;
      end else if (dur > 32'(cfg_i.sleep_press)) begin
        mode_d  = MODE_SLEEP;
        entry_d = now;
      end
    end

    // Indicator.
    case (mode_d)
      MODE_INIT: begin
        if (now - last_blink_q > BLINK_INIT_MS) begin
          lamp_d       = !lamp_q;
          last_blink_d = now;
        end
      end
      MODE_PAIRING: begin
        if (now - last_blink_q > BLINK_PAIRING_MS) begin
          lamp_d       = !lamp_q;
          last_blink_d = now;
        end
      end
      MODE_SYNCING: lamp_d = phase_i.sync_lit;
      MODE_RUNNING: lamp_d = 1'b1;
      MODE_SLEEP:   lamp_d = 1'b0;
      MODE_ERROR:   lamp_d = phase_i.err_toggle ? !lamp_q : 1'b0;
      default: ;
    endcase

    // Mode machine.
    case (mode_d)
      MODE_INIT: begin
        mode_d  = (own_d != UNPAIRED_ID) ? MODE_SYNCING : MODE_PAIRING;
        entry_d = now;
      end
      MODE_PAIRING: begin
        if (now - entry_d > 32'(cfg_i.pairing_timeout)) begin
          // Giving up keeps the old entry time.
          mode_d = (own_d != UNPAIRED_ID) ? MODE_SYNCING : MODE_ERROR;
        end else begin
          if (now - last_strobe_q > 32'(cfg_i.pair_retry_interval)) begin
            pair_req      = 1'b1;
            last_strobe_d = now;
          end
          if (item_i.link_id != UNPAIRED_ID && item_i.link_id != own_d) begin
            own_d   = item_i.link_id;
            save    = 1'b1;
            mode_d  = MODE_SYNCING;
            entry_d = now;
          end
        end
      end
      MODE_SYNCING: begin
        if (synced_q) begin
          mode_d  = MODE_RUNNING;
          entry_d = now;
        end else if (now - entry_d > 32'(cfg_i.sync_timeout)) begin
          resync  = 1'b1;
          entry_d = now;
        end
      end
      MODE_RUNNING: begin
        if (!synced_q && (now - last_sync_d > 32'(cfg_i.sync_timeout))) begin
          mode_d  = MODE_SYNCING;
          entry_d = now;
        end
        if (now - last_act_d > 32'(cfg_i.sleep_timeout)) begin
          mode_d  = MODE_SLEEP;
          entry_d = now;
        end
      end
      MODE_SLEEP: begin
        sleep_req = 1'b1;
        lamp_d    = 1'b0;
        mode_d    = MODE_SYNCING;
        entry_d   = now;
      end
      default: ;
    endcase

    // Link events reported after the pass.
    case (item_i.sync_report)
      SYNC_LOST: synced_d = 1'b0;
      SYNC_GAINED: begin
        synced_d    = 1'b1;
        last_sync_d = now;
        if (mode_d == MODE_SYNCING) begin
          mode_d = MODE_RUNNING;
        end
      end
      default: ;
    endcase
    if (item_i.link_ack) begin
      last_act_d = now;
    end

    res_o.led_on         = lamp_d;
    res_o.mode           = mode_d;
    res_o.pair_request   = pair_req;
    res_o.save_pairing   = save;
    res_o.resync_request = resync;
    res_o.sleep_request  = sleep_req;
    res_o.fuse_enable    = (mode_d == MODE_RUNNING) || (mode_d == MODE_SYNCING);
    res_o.send_enable    = (mode_d == MODE_RUNNING) && synced_d &&
                           (own_d != UNPAIRED_ID);
    res_o.paired_id      = own_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q     <= 1'b0;
      mode_q        <= MODE_INIT;
      entry_q       <= 32'd0;
      last_sync_q   <= 32'd0;
      last_act_q    <= 32'd0;
      last_blink_q  <= 32'd0;
      last_strobe_q <= 32'd0;
      press_start_q <= 32'd0;
      held_q        <= 1'b0;
      lamp_q        <= 1'b1;
      synced_q      <= 1'b0;
      own_q         <= UNPAIRED_ID;
    end else if (adv_i) begin
      started_q     <= started_d;
      mode_q        <= mode_d;
      entry_q       <= entry_d;
      last_sync_q   <= last_sync_d;
      last_act_q    <= last_act_d;
      last_blink_q  <= last_blink_d;
      last_strobe_q <= last_strobe_d;
      press_start_q <= press_start_d;
      held_q        <= held_d;
      lamp_q        <= lamp_d;
      synced_q      <= synced_d;
      own_q         <= own_d;
    end
  end

endmodule

/* design/tracker_mode_controller.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker mode controller
// One main-loop pass per input beat: button, indicator, mode machine and
// link events; one result beat per pass.
//
//   Channel   Direction  Signals
//   input     in         in_valid_i / in_ready_o, now_ms_i .. link_ack_i
//   result    out        out_valid_o / out_ready_i, led_on_o .. paired_id_o
//   config    in         cfg_we_i, cfg_idx_i, cfg_wdata_i (no handshake)
//
// A pass goes from input beat to result beat through the input register
// (with the divide-by-100 multiplier) and the pass logic ahead of the
// result register. One beat is accepted every cycle when results drain.
// Reset clears the mode state; the first pass afterwards picks the start mode.
// A stalled result holds the pass; the input register still takes one beat.
// ----------------------------------------------------------------------------
module tracker_mode_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] now_ms_i,
  input  logic        button_down_i,
  input  logic [7:0]  link_id_i,
  input  logic [1:0]  sync_report_i,
  input  logic        link_ack_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        led_on_o,
  output logic [2:0]  mode_o,
  output logic        pair_request_o,
  output logic        save_pairing_o,
  output logic        resync_request_o,
  output logic        sleep_request_o,
  output logic        fuse_enable_o,
  output logic        send_enable_o,
  output logic [7:0]  paired_id_o
);
  import tmc_pkg::*;

  tmc_cfg_t    cfg_q;
  tmc_item_t   item;
  tmc_phase_t  phase;
  tmc_result_t res;
  tmc_result_t res_q;
  logic        item_vld;
  logic        adv;
  logic        out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_id            <= RST_START_ID;
      cfg_q.start_fault         <= RST_START_FAULT;
      cfg_q.pairing_timeout     <= RST_PAIRING_TMO;
      cfg_q.sync_timeout        <= RST_SYNC_TMO;
      cfg_q.sleep_timeout       <= RST_SLEEP_TMO;
      cfg_q.pair_retry_interval <= RST_PAIR_RETRY;
      cfg_q.pairing_press       <= RST_PAIRING_PRESS;
      cfg_q.sleep_press         <= RST_SLEEP_PRESS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_ID:      cfg_q.start_id            <= cfg_wdata_i[7:0];
        CFG_START_FAULT:   cfg_q.start_fault         <= cfg_wdata_i[0];
        CFG_PAIRING_TMO:   cfg_q.pairing_timeout     <= cfg_wdata_i;
        CFG_SYNC_TMO:      cfg_q.sync_timeout        <= cfg_wdata_i;
        CFG_SLEEP_TMO:     cfg_q.sleep_timeout       <= cfg_wdata_i;
        CFG_PAIR_RETRY:    cfg_q.pair_retry_interval <= cfg_wdata_i;
        CFG_PAIRING_PRESS: cfg_q.pairing_press       <= cfg_wdata_i;
        CFG_SLEEP_PRESS:   cfg_q.sleep_press         <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pass runs when its input is held and the result slot is free or draining.
  assign adv = item_vld && (!out_vld_q || out_ready_i);

  tmc_in_stage u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .now_ms_i      (now_ms_i),
    .button_down_i (button_down_i),
    .link_id_i     (link_id_i),
    .sync_report_i (sync_report_i),
    .link_ack_i    (link_ack_i),
    .take_i        (adv),
    .vld_o         (item_vld),
    .item_o        (item)
  );

  tmc_phase u_phase (
    .hundreds_i (item.hundreds),
    .phase_o    (phase)
  );

  tmc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .item_i  (item),
    .phase_i (phase),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign led_on_o         = res_q.led_on;
  assign mode_o           = res_q.mode;
  assign pair_request_o   = res_q.pair_request;
  assign save_pairing_o   = res_q.save_pairing;
  assign resync_request_o = res_q.resync_request;
  assign sleep_request_o  = res_q.sleep_request;
  assign fuse_enable_o    = res_q.fuse_enable;
  assign send_enable_o    = res_q.send_enable;
  assign paired_id_o      = res_q.paired_id;

  a_send_needs_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_enable_o |-> mode_o == MODE_RUNNING &&
                                     paired_id_o != UNPAIRED_ID)
    else $error("send enable outside running or while unpaired");

  a_fuse_matches_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> fuse_enable_o ==
                    (mode_o == MODE_RUNNING || mode_o == MODE_SYNCING))
    else $error("fuse enable disagrees with mode");

  a_sleep_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && sleep_request_o |-> !led_on_o &&
      (mode_o == MODE_SYNCING || mode_o == MODE_RUNNING))
    else $error("sleep pass left LED on or wrong mode");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while result slot could drain");

  a_result_on_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("pass did not produce a result beat");

endmodule

/* bench/tracker_mode_controller_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tracker mode controller testbench
// Sends main-loop passes over the valid/ready input channel, predicts every
// result beat with an untimed model of the button, indicator and mode logic,
// and compares each field in order. Both channels idle and stall at random.
// The registers change between phases, including all-zero and all-ones
// settings, and one phase holds the output off long enough to back up the input.
// ----------------------------------------------------------------------------
module tracker_mode_controller_test;
  import tmc_pkg::*;

  // Sync report code that the block must treat like no event.
  localparam logic [1:0] SYNC_RESERVED = 2'd3;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_down;
    logic [7:0]  link_id;
    logic [1:0]  sync_report;
    logic        link_ack;
  } pass_t;

  class tracker_scoreboard;
    tmc_cfg_t    cfg;
    bit          started, held, lamp, synced;
    logic [2:0]  mode;
    logic [7:0]  own_id;
    logic [31:0] entry_t, sync_t, activity_t, blink_t, strobe_t, press_t;
    tmc_result_t pending_results[$];
    int unsigned mismatches, checked;

    function new();
      cfg.start_id            = RST_START_ID;
      cfg.start_fault         = RST_START_FAULT;
      cfg.pairing_timeout     = RST_PAIRING_TMO;
      cfg.sync_timeout        = RST_SYNC_TMO;
      cfg.sleep_timeout       = RST_SLEEP_TMO;
      cfg.pair_retry_interval = RST_PAIR_RETRY;
      cfg.pairing_press       = RST_PAIRING_PRESS;
      cfg.sleep_press         = RST_SLEEP_PRESS;
      started    = 1'b0;
      held       = 1'b0;
      lamp       = 1'b1;
      synced     = 1'b0;
      mode       = MODE_INIT;
      own_id     = UNPAIRED_ID;
      entry_t    = '0;
      sync_t     = '0;
      activity_t = '0;
      blink_t    = '0;
      strobe_t   = '0;
      press_t    = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_START_ID:      cfg.start_id = data[7:0];
        CFG_START_FAULT:   cfg.start_fault = data[0];
        CFG_PAIRING_TMO:   cfg.pairing_timeout = data;
        CFG_SYNC_TMO:      cfg.sync_timeout = data;
        CFG_SLEEP_TMO:     cfg.sleep_timeout = data;
        CFG_PAIR_RETRY:    cfg.pair_retry_interval = data;
        CFG_PAIRING_PRESS: cfg.pairing_press = data;
        default:           cfg.sleep_press = data;
      endcase
    endfunction

    // Runs one pass of the mode logic and queues the result it must produce.
    function void note_pass(pass_t p);
      tmc_result_t r;
      logic [31:0] now;
      logic [31:0] held_for;
      int unsigned slot;
      now = p.now_ms;
      r = '0;
      if (!started) begin
        started = 1'b1;
        own_id  = cfg.start_id;
        if (cfg.start_id == UNPAIRED_ID) mode = MODE_PAIRING;
        else if (cfg.start_fault) mode = MODE_ERROR;
        else mode = MODE_SYNCING;
        entry_t    = now;
        sync_t     = now;
        activity_t = now;
      end

      if (p.button_down && !held) begin
        held    = 1'b1;
        press_t = now;
      end else if (!p.button_down && held) begin
        held_for = now - press_t;
        held     = 1'b0;
        if (held_for > cfg.pairing_press) begin
          mode    = MODE_PAIRING;
          entry_t = now;
        end else if (held_for > cfg.sleep_press) begin
          mode    = MODE_SLEEP;
          entry_t = now;
        end
      end

      case (mode)
        MODE_INIT: begin
          if ((now - blink_t) > BLINK_INIT_MS) begin
            lamp    = !lamp;
            blink_t = now;
          end
        end
        MODE_PAIRING: begin
          if ((now - blink_t) > BLINK_PAIRING_MS) begin
            lamp    = !lamp;
            blink_t = now;
          end
        end
        MODE_SYNCING: begin
          slot = (now / 32'd100) % 32'd10;
          lamp = (slot == 0) || (slot == 2);
        end
        MODE_RUNNING: lamp = 1'b1;
        MODE_SLEEP:   lamp = 1'b0;
        MODE_ERROR: begin
          slot = (now / 32'd200) % 32'd6;
          lamp = (slot < 3) ? !lamp : 1'b0;
        end
        default: ;
      endcase

      case (mode)
        MODE_INIT: begin
          mode    = (own_id != UNPAIRED_ID) ? MODE_SYNCING : MODE_PAIRING;
          entry_t = now;
        end
        MODE_PAIRING: begin
          // A pairing timeout keeps the old entry time.
          if ((now - entry_t) > cfg.pairing_timeout) begin
            mode = (own_id != UNPAIRED_ID) ? MODE_SYNCING : MODE_ERROR;
          end else begin
            if ((now - strobe_t) > cfg.pair_retry_interval) begin
              r.pair_request = 1'b1;
              strobe_t       = now;
            end
            if (p.link_id != UNPAIRED_ID && p.link_id != own_id) begin
              own_id         = p.link_id;
              r.save_pairing = 1'b1;
              mode           = MODE_SYNCING;
              entry_t        = now;
            end
          end
        end
        MODE_SYNCING: begin
          if (synced) begin
            mode    = MODE_RUNNING;
            entry_t = now;
          end else if ((now - entry_t) > cfg.sync_timeout) begin
            r.resync_request = 1'b1;
            entry_t          = now;
          end
        end
        MODE_RUNNING: begin
          if (!synced && (now - sync_t) > cfg.sync_timeout) begin
            mode    = MODE_SYNCING;
            entry_t = now;
          end
          if ((now - activity_t) > cfg.sleep_timeout) begin
            mode    = MODE_SLEEP;
            entry_t = now;
          end
        end
        MODE_SLEEP: begin
          r.sleep_request = 1'b1;
          lamp            = 1'b0;
          mode            = MODE_SYNCING;
          entry_t         = now;
        end
        default: ;
      endcase

      if (p.sync_report == SYNC_LOST) begin
        synced = 1'b0;
      end else if (p.sync_report == SYNC_GAINED) begin
        synced = 1'b1;
        sync_t = now;
        if (mode == MODE_SYNCING) mode = MODE_RUNNING;
      end
      if (p.link_ack) activity_t = now;

      r.led_on      = lamp;
      r.mode        = mode;
      r.fuse_enable = (mode == MODE_RUNNING) || (mode == MODE_SYNCING);
      r.send_enable = (mode == MODE_RUNNING) && synced && (own_id != UNPAIRED_ID);
      r.paired_id   = own_id;
      pending_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(tmc_result_t got);
      tmc_result_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: result beat with no pass outstanding, expected none, got %h",
                 $time, got);
      end else begin
        want = pending_results.pop_front();
        checked++;
        compare_field("led_on", 8'(want.led_on), 8'(got.led_on));
        compare_field("mode", 8'(want.mode), 8'(got.mode));
        compare_field("pair_request", 8'(want.pair_request), 8'(got.pair_request));
        compare_field("save_pairing", 8'(want.save_pairing), 8'(got.save_pairing));
        compare_field("resync_request", 8'(want.resync_request), 8'(got.resync_request));
        compare_field("sleep_request", 8'(want.sleep_request), 8'(got.sleep_request));
        compare_field("fuse_enable", 8'(want.fuse_enable), 8'(got.fuse_enable));
        compare_field("send_enable", 8'(want.send_enable), 8'(got.send_enable));
        compare_field("paired_id", want.paired_id, got.paired_id);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CFG_START_ID;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] now_ms_i = '0;
  logic        button_down_i = 1'b0;
  logic [7:0]  link_id_i = UNPAIRED_ID;
  logic [1:0]  sync_report_i = SYNC_NONE;
  logic        link_ack_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        led_on_o;
  logic [2:0]  mode_o;
  logic        pair_request_o;
  logic        save_pairing_o;
  logic        resync_request_o;
  logic        sleep_request_o;
  logic        fuse_enable_o;
  logic        send_enable_o;
  logic [7:0]  paired_id_o;

  tracker_scoreboard sb;

  // Stimulus state shared between the generator and the phase control.
  logic [31:0] now_t = '0;
  logic [31:0] press_at = '0;
  logic [31:0] hold_len = '0;
  bit          btn_level = 1'b0;
  int unsigned advance_max = 100;
  int unsigned ack_pct = 20;
  int unsigned send_idle_max = 8;
  int unsigned recv_idle_max = 8;
  int unsigned hold_req = 0;
  int unsigned settings_loaded = 0;
  int unsigned passes_sent = 0;

  tracker_mode_controller u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .now_ms_i         (now_ms_i),
    .button_down_i    (button_down_i),
    .link_id_i        (link_id_i),
    .sync_report_i    (sync_report_i),
    .link_ack_i       (link_ack_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .led_on_o         (led_on_o),
    .mode_o           (mode_o),
    .pair_request_o   (pair_request_o),
    .save_pairing_o   (save_pairing_o),
    .resync_request_o (resync_request_o),
    .sleep_request_o  (sleep_request_o),
    .fuse_enable_o    (fuse_enable_o),
    .send_enable_o    (send_enable_o),
    .paired_id_o      (paired_id_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_regs(input logic [15:0] sid, input logic [15:0] sfault,
                           input logic [15:0] pair_tmo, input logic [15:0] sync_tmo,
                           input logic [15:0] sleep_tmo, input logic [15:0] retry,
                           input logic [15:0] pair_press, input logic [15:0] slp_press);
    write_reg(CFG_START_ID, sid);
    write_reg(CFG_START_FAULT, sfault);
    write_reg(CFG_PAIRING_TMO, pair_tmo);
    write_reg(CFG_SYNC_TMO, sync_tmo);
    write_reg(CFG_SLEEP_TMO, sleep_tmo);
    write_reg(CFG_PAIR_RETRY, retry);
    write_reg(CFG_PAIRING_PRESS, pair_press);
    write_reg(CFG_SLEEP_PRESS, slp_press);
    settings_loaded++;
  endtask

  task automatic load_random_regs();
    logic [15:0] slp_press;
    slp_press = 16'($urandom_range(500, 1));
    // Upper bits of the narrow registers carry noise that must be dropped.
    load_regs(16'($urandom_range(16'hFFFF, 0)), 16'($urandom_range(16'hFFFF, 0)),
              16'($urandom_range(3000, 200)), 16'($urandom_range(800, 50)),
              16'($urandom_range(4000, 500)), 16'($urandom_range(200, 0)),
              16'(slp_press + $urandom_range(1500, 1)), slp_press);
  endtask

  // Entered just after the clock rises; returns on the rising clock that took the beat.
  task automatic send_pass(input pass_t p);
    int unsigned gap;
    gap = $urandom_range(send_idle_max, 0);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    now_ms_i      <= p.now_ms;
    button_down_i <= p.button_down;
    link_id_i     <= p.link_id;
    sync_report_i <= p.sync_report;
    link_ack_i    <= p.link_ack;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pass(p);
    passes_sent++;
  endtask

  task automatic drive_pass(input logic [31:0] t, input bit btn, input logic [7:0] link,
                            input logic [1:0] rep, input bit ack);
    pass_t p;
    p.now_ms      = t;
    p.button_down = btn;
    p.link_id     = link;
    p.sync_report = rep;
    p.link_ack    = ack;
    send_pass(p);
  endtask

  // Drops valid and waits until every queued result beat has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly forward-moving time with whole button presses sized around the
  // press thresholds; now and then a jump to an arbitrary time.
  task automatic run_traffic(input int unsigned count);
    pass_t p;
    int unsigned r, advance;
    int h;
    repeat (count) begin
      r = $urandom_range(99, 0);
      advance = (r < 4) ? $urandom() : $urandom_range(advance_max, 0);
      if (btn_level && r >= 4 && (now_t + advance - press_at) >= hold_len)
        now_t = press_at + hold_len;
      else
        now_t = now_t + advance;

      if (btn_level) begin
        if ((now_t - press_at) >= hold_len) btn_level = 1'b0;
      end else if ($urandom_range(99, 0) < 10) begin
        btn_level = 1'b1;
        press_at  = now_t;
        case ($urandom_range(3, 0))
          0: h = int'(sb.cfg.sleep_press) + int'($urandom_range(2, 0)) - 1;
          1: h = int'(sb.cfg.pairing_press) + int'($urandom_range(2, 0)) - 1;
          2: h = (int'(sb.cfg.sleep_press) + int'(sb.cfg.pairing_press)) / 2 + 1;
          default: h = int'($urandom_range(sb.cfg.pairing_press + 300, 0));
        endcase
        if (h < 0) h = 0;
        hold_len = 32'(h);
      end

      p.now_ms      = now_t;
      p.button_down = btn_level;
      r = $urandom_range(99, 0);
      if (r < 55) p.link_id = UNPAIRED_ID;
      else if (r < 75) p.link_id = sb.own_id;
      else if (r < 92) p.link_id = sb.own_id + 8'd1;
      else p.link_id = 8'($urandom_range(255, 0));
      r = $urandom_range(99, 0);
      if (r < 70) p.sync_report = SYNC_NONE;
      else if (r < 82) p.sync_report = SYNC_LOST;
      else if (r < 95) p.sync_report = SYNC_GAINED;
      else p.sync_report = SYNC_RESERVED;
      p.link_ack = ($urandom_range(99, 0) < ack_pct);
      send_pass(p);
    end
  endtask

  // Output side: per-beat random stall, plus a long hold-off on request.
  initial begin : result_sink
    int unsigned stall;
    tmc_result_t got;
    stall = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req != 0) begin
        stall    = hold_req;
        hold_req = 0;
      end
      out_ready_i <= (stall == 0);
      if (stall != 0) stall--;
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.led_on         = led_on_o;
        got.mode           = mode_o;
        got.pair_request   = pair_request_o;
        got.save_pairing   = save_pairing_o;
        got.resync_request = resync_request_o;
        got.sleep_request  = sleep_request_o;
        got.fuse_enable    = fuse_enable_o;
        got.send_enable    = send_enable_o;
        got.paired_id      = paired_id_o;
        sb.check_result(got);
        stall = $urandom_range(recv_idle_max, 0);
      end
    end
  end

  initial begin : watchdog
    #5000000;
    $display("tracker_mode_controller_test NOT OK");
    $finish;
  end

  initial begin : main_seq
    sb = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Unpaired start with the fault flag set must still begin in pairing.
    load_regs(16'(UNPAIRED_ID), 16'd1, 16'd1000, 16'd300, 16'd2000, 16'd50, 16'd600,
              16'd200);
    @(posedge clk_i);

    drive_pass(32'd0,    1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    drive_pass(32'd60,   1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    drive_pass(32'd120,  1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    // Pairing runs out with no id learned, so the block falls into error.
    drive_pass(32'd1200, 1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    drive_pass(32'd1300, 1'b1, UNPAIRED_ID, SYNC_RESERVED, 1'b0);
    drive_pass(32'd1500, 1'b1, UNPAIRED_ID, SYNC_NONE, 1'b0);
    // A press longer than the pairing threshold takes the block out of error into pairing.
    drive_pass(32'd2000, 1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    drive_pass(32'd2100, 1'b0, 8'h00,       SYNC_NONE, 1'b0);
    drive_pass(32'd2200, 1'b0, 8'h00,       SYNC_GAINED, 1'b0);
    drive_pass(32'd2300, 1'b0, UNPAIRED_ID, SYNC_NONE, 1'b1);
    drive_pass(32'd2400, 1'b0, UNPAIRED_ID, SYNC_LOST, 1'b0);
    drive_pass(32'd2800, 1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    drive_pass(32'd3200, 1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    drive_pass(32'd3300, 1'b0, UNPAIRED_ID, SYNC_GAINED, 1'b0);
    // No acknowledgment for longer than the sleep timeout.
    drive_pass(32'd5400, 1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    drive_pass(32'd5500, 1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    drive_pass(32'd5600, 1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    drive_pass(32'd5700, 1'b1, UNPAIRED_ID, SYNC_NONE, 1'b1);
    drive_pass(32'd6000, 1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    drive_pass(32'd6100, 1'b1, UNPAIRED_ID, SYNC_NONE, 1'b0);
    // Paired device re-enters pairing and then times out back to syncing.
    drive_pass(32'd7000, 1'b0, UNPAIRED_ID, SYNC_NONE, 1'b0);
    drive_pass(32'd8100, 1'b0, 8'h00,       SYNC_NONE, 1'b0);
    drive_pass(32'hFFFF_FFFF, 1'b0, 8'hFF,  SYNC_GAINED, 1'b1);
    drive_pass(32'd5,    1'b0, 8'h5A,       SYNC_NONE, 1'b0);
    drive_pass(32'd100,  1'b0, 8'hFE,       SYNC_RESERVED, 1'b1);
    now_t = 32'd100;
    settle();

    // Start registers written late must change nothing.
    load_regs(16'h0005, 16'd0, 16'd1000, 16'd300, 16'd2000, 16'd50, 16'd600, 16'd200);
    advance_max = 150;
    ack_pct     = 20;
    run_traffic(100);
    settle();

    // Every threshold at zero, with no idling on either side.
    load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_idle_max = 0;
    recv_idle_max = 0;
    advance_max   = 3;
    ack_pct       = 50;
    run_traffic(60);
    settle();

    // Every register at its largest value.
    load_regs(16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_idle_max = 8;
    recv_idle_max = 8;
    advance_max   = 6000;
    ack_pct       = 10;
    run_traffic(80);
    settle();

    // Output held off while the input keeps offering, then a full pause.
    load_random_regs();
    advance_max   = 250;
    ack_pct       = 15;
    send_idle_max = 0;
    hold_req      = 60;
    run_traffic(60);
    settle();
    send_idle_max = 8;
    run_traffic(60);
    settle();

    // Default register values, with time running across the wrap.
    load_regs(16'(RST_START_ID), 16'(RST_START_FAULT), RST_PAIRING_TMO, RST_SYNC_TMO,
              RST_SLEEP_TMO, RST_PAIR_RETRY, RST_PAIRING_PRESS, RST_SLEEP_PRESS);
    now_t       = 32'hFFFF_0000;
    advance_max = 4000;
    ack_pct     = 10;
    run_traffic(60);
    settle();

    load_random_regs();
    send_idle_max = 3;
    recv_idle_max = 5;
    advance_max   = 200;
    ack_pct       = 25;
    run_traffic(60);
    settle();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d passes under %0d register settings; %0d result beats checked.",
             passes_sent, settings_loaded, sb.checked);
    $display("Run included a long output stall, an input pause and time wrap-around.");
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("tracker_mode_controller_test OK");
    end else begin
      $display("tracker_mode_controller_test NOT OK");
    end
    $finish;
  end

endmodule
